FILE: rtl/typed_byte_memory_access_macros.svh
// Assertion macros shared by the typed byte memory access modules.
`ifndef TYPED_BYTE_MEMORY_ACCESS_MACROS_SVH
`define TYPED_BYTE_MEMORY_ACCESS_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication or plain condition, checked outside reset.
`define TBMA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle requires a consequence in the next cycle.
`define TBMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TBMA_ASSERT(label, clk, rst, prop, msg)
`define TBMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/tbma_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none
package tbma_pkg;

  localparam int MEM_BYTES_DEF = 1024;
  localparam int STR_MAX_DEF   = 63;

  localparam int LIMIT_W = 11;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 32;
  localparam int SPAN_W  = 17;
  localparam int IDX_W   = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  localparam logic [1:0] WC_BYTE   = 2'd0;
  localparam logic [1:0] WC_HALF   = 2'd1;
  localparam logic [1:0] WC_WORD   = 2'd2;
  localparam logic [1:0] WC_STRING = 2'd3;

  typedef enum logic [1:0] {
    RES_VIOL,
    RES_WORD,
    RES_CHAR,
    RES_TERM
  } res_sel_t;

  typedef struct packed {
    logic     clear_step;
    logic     capture;
    logic     write_byte;
    logic     str_violate;
    logic     step;
    logic     read;
    logic     accumulate;
    logic     emit;
    res_sel_t res_sel;
  } tbma_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_string;
    logic cur_beyond;
    logic span_beyond;
    logic ptr_beyond;
    logic str_stopped;
    logic i_last;
    logic str_end;
    logic byte_zero;
    logic clear_done;
  } tbma_status_t;

endpackage
`default_nettype wire

FILE: rtl/typed_byte_memory_access.sv
// Top level: typed little-endian byte memory with string stores and loads.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  request   | start / busy              | kind, width_code, address, write_value,
//            |                           | string_first
//  result    | result_valid (one cycle)  | read_value, violation, is_text, last
//  config    | cfg_write                 | cfg_data (size limit in bytes)
//
// After reset the memory is zeroed one byte per cycle, and busy stays high through
// the whole clear pass, so no transaction is taken before it ends.
// A transaction is captured and then decoded; a store then writes one byte per cycle
// through the single memory write port, and a load takes each byte in two steps
// (registered read, then accumulate) before it moves on to the next byte.
// A string load reads and emits one character at a time, up to STR_MAX, plus a terminator.
// The result strobe comes in the cycle after its internal decision; the receiver cannot stall.
`default_nettype none
module typed_byte_memory_access #(
  parameter int MEM_BYTES = tbma_pkg::MEM_BYTES_DEF,
  parameter int STR_MAX   = tbma_pkg::STR_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [1:0]                         width_code,
  input  logic [tbma_pkg::ADDR_W-1:0]        address,
  input  logic [tbma_pkg::DATA_W-1:0]        write_value,
  input  logic                               string_first,
  input  logic                               cfg_write,
  input  logic [tbma_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                               result_valid,
  output logic signed [tbma_pkg::DATA_W-1:0] read_value,
  output logic                               violation,
  output logic                               is_text,
  output logic                               last
);
  import tbma_pkg::*;

  tbma_cmd_t    cmd;
  tbma_status_t status;

  tbma_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  tbma_datapath #(
    .MEM_BYTES (MEM_BYTES),
    .STR_MAX   (STR_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .width_code   (width_code),
    .address      (address),
    .write_value  (write_value),
    .string_first (string_first),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .read_value   (read_value),
    .violation    (violation),
    .is_text      (is_text),
    .last         (last)
  );

endmodule
`default_nettype wire

FILE: rtl/tbma_datapath.sv
// Datapath: byte memory, limit register, string pointer, operand and result registers.
`default_nettype none
`include "typed_byte_memory_access_macros.svh"
module tbma_datapath #(
  parameter int MEM_BYTES = tbma_pkg::MEM_BYTES_DEF,
  parameter int STR_MAX   = tbma_pkg::STR_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tbma_pkg::LIMIT_W-1:0]      cfg_data,
  input  logic                              kind,
  input  logic [1:0]                        width_code,
  input  logic [tbma_pkg::ADDR_W-1:0]       address,
  input  logic [tbma_pkg::DATA_W-1:0]       write_value,
  input  logic                              string_first,
  input  tbma_pkg::tbma_cmd_t               cmd,
  output tbma_pkg::tbma_status_t            status,
  output logic                              result_valid,
  output logic signed [tbma_pkg::DATA_W-1:0] read_value,
  output logic                              violation,
  output logic                              is_text,
  output logic                              last
);
  import tbma_pkg::*;

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam logic [SPAN_W-1:0] CAP          = SPAN_W'(MEM_BYTES);
  localparam logic [IDX_W-1:0]  IDX_STR_LAST = IDX_W'(STR_MAX - 1);
  localparam logic [AW-1:0]     CLEAR_LAST   = AW'(MEM_BYTES - 1);

  logic [7:0] mem [MEM_BYTES];

  logic [LIMIT_W-1:0] mem_limit;
  logic               op_kind;
  logic [1:0]         op_width;
  logic [ADDR_W-1:0]  op_addr;
  logic [DATA_W-1:0]  op_data;
  logic [IDX_W-1:0]   idx;
  logic [DATA_W-1:0]  acc;
  logic [ADDR_W-1:0]  str_ptr;
  logic               str_stopped;
  logic [AW-1:0]      clear_idx;
  logic [7:0]         rdata;

  logic [SPAN_W-1:0] lim;
  logic [SPAN_W-1:0] cur_addr;
  logic [SPAN_W-1:0] span_end;
  logic [IDX_W-1:0]  last_off;
  logic [DATA_W-1:0] acc_next;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic              is_string;

  assign is_string = (op_width == WC_STRING);

  always_comb begin
    case (op_width)
      WC_BYTE: last_off = IDX_W'(0);
      WC_HALF: last_off = IDX_W'(1);
      default: last_off = IDX_W'(3);
    endcase
  end

  // The active limit is the configured size, capped at the memory capacity.
  assign lim      = (SPAN_W'(mem_limit) < CAP) ? SPAN_W'(mem_limit) : CAP;
  assign cur_addr = SPAN_W'(op_addr) + SPAN_W'(idx);
  assign span_end = SPAN_W'(op_addr) + SPAN_W'(last_off);

  always_comb begin
    acc_next = acc;
    acc_next[{idx[1:0], 3'b000} +: 8] = rdata;
  end

  assign status.is_load     = (op_kind == KIND_LOAD);
  assign status.is_string   = is_string;
  assign status.cur_beyond  = (cur_addr >= lim);
  assign status.span_beyond = (span_end >= lim);
  assign status.ptr_beyond  = (SPAN_W'(str_ptr) >= lim);
  assign status.str_stopped = str_stopped;
  assign status.i_last      = (idx == last_off);
  assign status.str_end     = (idx == IDX_STR_LAST) || ((cur_addr + SPAN_W'(1)) >= lim);
  assign status.byte_zero   = (rdata == 8'd0);
  assign status.clear_done  = (clear_idx == CLEAR_LAST);

  assign wr_en = cmd.clear_step || cmd.write_byte;

  always_comb begin
    if (cmd.clear_step) begin
      wr_addr = clear_idx;
      wr_data = 8'd0;
    end else begin
      wr_addr = is_string ? str_ptr[AW-1:0] : cur_addr[AW-1:0];
      wr_data = op_data[{idx[1:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rdata <= mem[cur_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind  <= kind;
      op_width <= width_code;
      op_addr  <= address;
      op_data  <= write_value;
      idx      <= '0;
      acc      <= '0;
    end else begin
      if (cmd.step) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.accumulate) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit   <= LIMIT_RESET;
      str_ptr     <= '0;
      str_stopped <= 1'b0;
      clear_idx   <= '0;
    end else begin
      if (cfg_write) begin
        mem_limit <= cfg_data;
      end
      if (cmd.clear_step) begin
        clear_idx <= clear_idx + AW'(1);
      end
      // A first character restarts the string transaction at its own address.
      if (cmd.capture && kind == KIND_STORE && width_code == WC_STRING && string_first) begin
        str_ptr     <= address;
        str_stopped <= 1'b0;
      end else if (cmd.write_byte && is_string) begin
        str_ptr <= str_ptr + ADDR_W'(1);
      end else if (cmd.str_violate) begin
        str_stopped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.res_sel)
        RES_VIOL: begin
          read_value <= '0;
          violation  <= 1'b1;
          is_text    <= 1'b0;
          last       <= 1'b1;
        end
        RES_WORD: begin
          read_value <= acc_next;
          violation  <= 1'b0;
          is_text    <= 1'b0;
          last       <= 1'b1;
        end
        RES_CHAR: begin
          read_value <= DATA_W'(rdata);
          violation  <= 1'b0;
          is_text    <= 1'b1;
          last       <= 1'b0;
        end
        default: begin
          read_value <= '0;
          violation  <= 1'b0;
          is_text    <= 1'b1;
          last       <= 1'b1;
        end
      endcase
    end
  end

  `TBMA_ASSERT(a_viol_shape, clk, rst, (result_valid && violation) |-> (read_value == 0 && last && !is_text), "violation result must be a zero final non-text result")
  `TBMA_ASSERT(a_only_text_continues, clk, rst, (result_valid && !last) |-> (is_text && !violation), "only string characters may be followed by more results")
  `TBMA_ASSERT(a_store_lim, clk, rst, cmd.write_byte |-> (is_string || cur_addr < lim), "store past limit")

endmodule
`default_nettype wire

FILE: rtl/tbma_ctrl.sv
// Controller: sequences the reset clear, stores, loads and string walks.
`default_nettype none
`include "typed_byte_memory_access_macros.svh"
module tbma_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  tbma_pkg::tbma_status_t status,
  output tbma_pkg::tbma_cmd_t    cmd
);
  import tbma_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECODE = 10'b0000000100,
    S_STORE  = 10'b0000001000,
    S_SSTORE = 10'b0000010000,
    S_LREAD  = 10'b0000100000,
    S_LACC   = 10'b0001000000,
    S_SREAD  = 10'b0010000000,
    S_SCHAR  = 10'b0100000000,
    S_STERM  = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_sel = RES_VIOL;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.is_load) begin
          state_next = status.is_string ? S_SSTORE : S_STORE;
        end else if (status.cur_beyond || (!status.is_string && status.span_beyond)) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_VIOL;
          state_next  = S_IDLE;
        end else begin
          state_next = status.is_string ? S_SREAD : S_LREAD;
        end
      end
      S_STORE: begin
        // Bytes below the limit stay written when a later byte violates.
        if (status.cur_beyond) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_VIOL;
          state_next  = S_IDLE;
        end else begin
          cmd.write_byte = 1'b1;
          if (status.i_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_SSTORE: begin
        state_next = S_IDLE;
        if (!status.str_stopped) begin
          if (status.ptr_beyond) begin
            cmd.emit        = 1'b1;
            cmd.res_sel     = RES_VIOL;
            cmd.str_violate = 1'b1;
          end else begin
            cmd.write_byte = 1'b1;
          end
        end
      end
      S_LREAD: begin
        cmd.read   = 1'b1;
        state_next = S_LACC;
      end
      S_LACC: begin
        cmd.accumulate = 1'b1;
        if (status.i_last) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_WORD;
          state_next  = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_LREAD;
        end
      end
      S_SREAD: begin
        cmd.read   = 1'b1;
        state_next = S_SCHAR;
      end
      S_SCHAR: begin
        cmd.emit = 1'b1;
        if (status.byte_zero) begin
          cmd.res_sel = RES_TERM;
          state_next  = S_IDLE;
        end else begin
          cmd.res_sel = RES_CHAR;
          cmd.step    = 1'b1;
          state_next  = status.str_end ? S_STERM : S_SREAD;
        end
      end
      S_STERM: begin
        cmd.emit    = 1'b1;
        cmd.res_sel = RES_TERM;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `TBMA_ASSERT(a_emit_active, clk, rst, cmd.emit |-> (state != S_IDLE && state != S_CLEAR), "result emitted outside a transaction")
  `TBMA_ASSERT_NEXT(a_read_used, clk, rst, cmd.read, (state == S_LACC || state == S_SCHAR), "read data not consumed in the following cycle")
  `TBMA_ASSERT(a_port_clash, clk, rst, !(cmd.write_byte && (cmd.read || cmd.clear_step)), "memory write collides with a read or the clear pass")

endmodule
`default_nettype wire
